@@ design/kpt_pkg.sv @@
`default_nettype none

package kpt_pkg;

    // width of every measurement, estimate and variance field and configuration register on the ports
    localparam int IO_WIDTH = 32;

    localparam int DATA_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF  = 16;

    // configuration register map
    localparam int CFG_IDX_W = 4;
    localparam logic [CFG_IDX_W-1:0] REG_INIT_X     = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INIT_Y     = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_INIT_COV   = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MEAS_NOISE = 4'd3;

    // register reset values: 4.0, 0.0, 1000.0 and 0.1 in Q16.16
    localparam logic [IO_WIDTH-1:0] INIT_X_RST     = 32'd262144;
    localparam logic [IO_WIDTH-1:0] INIT_Y_RST     = 32'd0;
    localparam logic [IO_WIDTH-1:0] INIT_COV_RST   = 32'd65536000;
    localparam logic [IO_WIDTH-1:0] MEAS_NOISE_RST = 32'd6554;

    typedef struct packed {
        logic signed [IO_WIDTH-1:0] meas_x;
        logic signed [IO_WIDTH-1:0] meas_y;
        logic                       restart;
    } t_in_item;

    typedef struct packed {
        logic signed [IO_WIDTH-1:0] est_x;
        logic signed [IO_WIDTH-1:0] est_y;
        logic        [IO_WIDTH-1:0] var_x;
        logic        [IO_WIDTH-1:0] var_y;
    } t_out_item;

    // controller to datapath commands
    typedef struct packed {
        logic load;      // capture a new item and form prediction
        logic reload;    // take the starting point from configuration
        logic div_step;  // one restoring division bit
        logic mul_init;  // derive the second gain fraction, clear products
        logic mul_step;  // one shift-add multiplier bit
        logic commit;    // write new estimate and variance
    } t_cmd;

endpackage

`default_nettype wire

@@ design/kpt_ctrl.sv @@
`default_nettype none

module kpt_ctrl
    import kpt_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    input  wire logic i_restart,
    output logic      o_in_stall,
    output logic      o_out_valid,
    input  wire logic i_out_stall,
    output t_cmd      o_cmd
);

    localparam int CNT_W = $clog2(FRAC_BITS + 1);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(FRAC_BITS);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_DIV   = 3'd1;
    localparam logic [2:0] S_MINIT = 3'd2;
    localparam logic [2:0] S_MUL   = 3'd3;
    localparam logic [2:0] S_DONE  = 3'd4;

    logic [2:0]       r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_started, n_started;
    logic             r_out_valid, n_out_valid;
    logic             w_accept;
    logic             w_commit;

    assign o_in_stall  = (r_state != S_IDLE) || !i_rst_n;
    assign o_out_valid = r_out_valid;
    assign w_accept    = i_in_valid && (r_state == S_IDLE);
    assign w_commit    = (r_state == S_DONE) && (!r_out_valid || !i_out_stall);

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_started   = r_started;
        n_out_valid = r_out_valid && i_out_stall;
        o_cmd       = '0;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    o_cmd.load   = 1'b1;
                    o_cmd.reload = !r_started || i_restart;
                    n_started    = 1'b1;
                    n_cnt        = '0;
                    n_state      = S_DIV;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                n_cnt          = r_cnt + 1'b1;
                if (r_cnt == CNT_LAST) begin
                    n_state = S_MINIT;
                end
            end
            S_MINIT: begin
                o_cmd.mul_init = 1'b1;
                n_cnt          = '0;
                n_state        = S_MUL;
            end
            S_MUL: begin
                o_cmd.mul_step = 1'b1;
                n_cnt          = r_cnt + 1'b1;
                if (r_cnt == CNT_LAST) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                // wait until the output register is free
                if (w_commit) begin
                    o_cmd.commit = 1'b1;
                    n_out_valid  = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_started   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_started   <= n_started;
            r_out_valid <= n_out_valid;
        end
    end

    a_commit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_commit |-> (!r_out_valid || !i_out_stall))
        else $error("commit while output register still holds a result");

    a_valid_from_commit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(w_commit))
        else $error("output valid raised without a commit");

    a_accept_starts_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == S_DIV) && (r_cnt == '0))
        else $error("accepted transaction did not start the division");

    a_mul_starts_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MINIT) |=> (r_state == S_MUL) && (r_cnt == '0))
        else $error("multiply phase did not start from bit zero");

endmodule

`default_nettype wire

@@ design/kpt_axis.sv @@
`default_nettype none

module kpt_axis
    import kpt_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
    input  wire logic                i_clk,
    input  wire t_cmd                i_cmd,
    input  wire logic [IO_WIDTH-1:0] i_meas,
    input  wire logic [IO_WIDTH-1:0] i_init_pos,
    input  wire logic [IO_WIDTH-1:0] i_init_var,
    input  wire logic [IO_WIDTH-1:0] i_noise,
    output logic      [IO_WIDTH-1:0] o_est,
    output logic      [IO_WIDTH-1:0] o_var
);

    localparam int DW   = DATA_WIDTH;
    localparam int FB   = FRAC_BITS;
    localparam int AW_E = DW + FB + 2;
    localparam int AW_P = DW + FB + 1;
    localparam logic [FB:0] ONE_Q = {1'b1, {FB{1'b0}}};

    // filter state
    logic [DW-1:0] r_est;
    logic [DW-1:0] r_var;
    logic [DW-1:0] r_prev;
    // per-item working registers
    logic [DW-1:0]          r_meas;
    logic signed [DW+1:0]   r_pred;
    logic [DW:0]            r_emag;
    logic                   r_eneg;
    logic [DW-1:0]          r_p;
    logic [DW:0]            r_s;
    logic [DW+1:0]          r_rem;
    logic [FB:0]            r_k;
    logic [FB:0]            r_l;
    logic [AW_E-1:0]        r_acc_e;
    logic [AW_P-1:0]        r_acc_p;

    logic [DW-1:0]        w_meas;
    logic [DW-1:0]        w_base_est;
    logic [DW-1:0]        w_base_prev;
    logic [DW-1:0]        w_p;
    logic [DW-1:0]        w_noise;
    logic signed [DW+1:0] w_pred;
    logic signed [DW:0]   w_err;
    logic [DW:0]          w_err_u;
    logic [DW:0]          w_emag;
    logic [DW:0]          w_s;
    logic                 w_ge;
    logic [DW+1:0]        w_rem_sub;
    logic                 w_s_zero;
    logic                 w_rem_nz;
    logic [FB:0]          w_l;
    logic [DW+1:0]        w_corr_mag;
    logic signed [DW+2:0] w_corr;
    logic signed [DW+2:0] w_sum;
    logic                 w_fits;
    logic [DW-1:0]        w_sat;

    assign w_meas      = DW'(i_meas);
    assign w_noise     = DW'(i_noise);
    assign w_base_est  = i_cmd.reload ? DW'(i_init_pos) : r_est;
    assign w_base_prev = i_cmd.reload ? DW'(i_init_pos) : r_prev;
    assign w_p         = i_cmd.reload ? DW'(i_init_var) : r_var;

    // prediction and innovation at full precision
    assign w_pred  = (DW+2)'($signed(w_base_est)) + (DW+2)'($signed(w_meas))
                   - (DW+2)'($signed(w_base_prev));
    assign w_err   = (DW+1)'($signed(w_base_prev)) - (DW+1)'($signed(w_base_est));
    assign w_err_u = w_err;
    assign w_emag  = w_err_u[DW] ? ((~w_err_u) + 1'b1) : w_err_u;
    assign w_s     = {1'b0, w_p} + {1'b0, w_noise};

    // restoring division, one quotient bit per step
    assign w_ge      = (r_rem >= {1'b0, r_s});
    assign w_rem_sub = w_ge ? (r_rem - {1'b0, r_s}) : r_rem;

    // second fraction from the first one and its remainder
    assign w_s_zero = (r_s == '0);
    assign w_rem_nz = (r_rem != '0);
    assign w_l      = ONE_Q - r_k - (FB+1)'(w_rem_nz);

    // correction, truncated toward zero, then saturated estimate
    assign w_corr_mag = r_acc_e[AW_E-1:FB];
    assign w_corr     = r_eneg ? -$signed({1'b0, w_corr_mag}) : $signed({1'b0, w_corr_mag});
    assign w_sum      = (DW+3)'(r_pred) + w_corr;
    assign w_fits     = (&w_sum[DW+2:DW-1]) || !(|w_sum[DW+2:DW-1]);
    assign w_sat      = w_fits ? w_sum[DW-1:0]
                      : (w_sum[DW+2] ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}});

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_meas <= w_meas;
            r_pred <= w_pred;
            r_emag <= w_emag;
            r_eneg <= w_err_u[DW];
            r_p    <= w_p;
            r_s    <= w_s;
            r_rem  <= {2'b00, w_p};
            r_k    <= '0;
        end
        if (i_cmd.div_step) begin
            r_rem <= {w_rem_sub[DW:0], 1'b0};
            r_k   <= {r_k[FB-1:0], w_ge};
        end
        if (i_cmd.mul_init) begin
            r_k     <= w_s_zero ? '0 : r_k;
            r_l     <= w_s_zero ? '0 : w_l;
            r_acc_e <= '0;
            r_acc_p <= '0;
        end
        if (i_cmd.mul_step) begin
            r_acc_e <= {r_acc_e[AW_E-2:0], 1'b0} + (r_k[FB] ? AW_E'(r_emag) : '0);
            r_acc_p <= {r_acc_p[AW_P-2:0], 1'b0} + (r_l[FB] ? AW_P'(r_p) : '0);
            r_k     <= {r_k[FB-1:0], 1'b0};
            r_l     <= {r_l[FB-1:0], 1'b0};
        end
        if (i_cmd.commit) begin
            r_est  <= w_sat;
            r_var  <= r_acc_p[FB+DW-1:FB];
            r_prev <= r_meas;
        end
    end

    assign o_est = IO_WIDTH'(r_est);
    assign o_var = IO_WIDTH'(r_var);

endmodule

`default_nettype wire

@@ design/kalman_position_tracker_2d.sv @@
`default_nettype none

// Two-axis position tracker: each (x,y) measurement transaction runs through two
// independent scalar Kalman filters that work side by side, and returns the new
// estimate (saturated) and variance per axis. An item is worked through the
// restoring divider that forms the gain and then the shift-add multiplier that
// applies it, each retiring one bit per cycle; the result is committed once the
// previous result is no longer held by output stall, and no new item is accepted
// until then. A finished result waits in the output register while the next
// item is taken.
// Configuration is to be written through the cfg port only while no item is in
// flight; the block itself does not enforce this. The first item after reset,
// or one with restart set, starts from the configured position and covariance.
module kalman_position_tracker_2d
    import kpt_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    output logic                      o_in_stall,
    input  wire t_in_item             i_in_data,
    output logic                      o_out_valid,
    input  wire logic                 i_out_stall,
    output t_out_item                 o_out_data,
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [IO_WIDTH-1:0]  i_cfg_data
);

    logic [IO_WIDTH-1:0] r_init_x;
    logic [IO_WIDTH-1:0] r_init_y;
    logic [IO_WIDTH-1:0] r_init_cov;
    logic [IO_WIDTH-1:0] r_meas_noise;
    t_cmd                w_cmd;
    logic [IO_WIDTH-1:0] w_est_x;
    logic [IO_WIDTH-1:0] w_est_y;
    logic [IO_WIDTH-1:0] w_var_x;
    logic [IO_WIDTH-1:0] w_var_y;

    assign o_cfg_ready = i_rst_n;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_init_x     <= INIT_X_RST;
            r_init_y     <= INIT_Y_RST;
            r_init_cov   <= INIT_COV_RST;
            r_meas_noise <= MEAS_NOISE_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                REG_INIT_X:     r_init_x     <= i_cfg_data;
                REG_INIT_Y:     r_init_y     <= i_cfg_data;
                REG_INIT_COV:   r_init_cov   <= i_cfg_data;
                REG_MEAS_NOISE: r_meas_noise <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    kpt_ctrl #(
        .FRAC_BITS (FRAC_BITS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_restart   (i_in_data.restart),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_cmd       (w_cmd)
    );

    kpt_axis #(
        .DATA_WIDTH (DATA_WIDTH),
        .FRAC_BITS  (FRAC_BITS)
    ) u_axis_x (
        .i_clk      (i_clk),
        .i_cmd      (w_cmd),
        .i_meas     (i_in_data.meas_x),
        .i_init_pos (r_init_x),
        .i_init_var (r_init_cov),
        .i_noise    (r_meas_noise),
        .o_est      (w_est_x),
        .o_var      (w_var_x)
    );

    kpt_axis #(
        .DATA_WIDTH (DATA_WIDTH),
        .FRAC_BITS  (FRAC_BITS)
    ) u_axis_y (
        .i_clk      (i_clk),
        .i_cmd      (w_cmd),
        .i_meas     (i_in_data.meas_y),
        .i_init_pos (r_init_y),
        .i_init_var (r_init_cov),
        .i_noise    (r_meas_noise),
        .o_est      (w_est_y),
        .o_var      (w_var_y)
    );

    // filter state doubles as the output register: it only changes on commit
    assign o_out_data.est_x = w_est_x;
    assign o_out_data.est_y = w_est_y;
    assign o_out_data.var_x = w_var_x;
    assign o_out_data.var_y = w_var_y;

endmodule

`default_nettype wire

@@ verif/tb.sv @@
module tb;
    import kpt_pkg::*;

    localparam int FRAC           = FRAC_BITS_DEF;
    localparam int CALM_ITEMS     = 150;
    localparam int RANDOM_ITEMS   = 1000;
    localparam int HOLD_AT        = 400;
    localparam int HOLD_LEN       = 300;
    localparam int TAIL_CYCLES    = 60;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int PRINT_CAP      = 200;

    localparam longint EST_MAX = 64'sd2147483647;
    localparam longint EST_MIN = -64'sd2147483648;

    // indexes past the register map, writes there must be ignored
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED_LO = REG_MEAS_NOISE + 1'b1;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED_HI = '1;

    typedef struct {
        logic                 is_cfg;
        logic [CFG_IDX_W-1:0] index;
        logic [IO_WIDTH-1:0]  value;
        t_in_item             item;
    } t_entry;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    logic                 in_stall;
    t_in_item             in_data = '0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    t_out_item            out_data;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [IO_WIDTH-1:0]  cfg_data = '0;

    kalman_position_tracker_2d uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // tracker copy: configuration and per-axis filter state
    logic signed [IO_WIDTH-1:0] trk_init_x = INIT_X_RST;
    logic signed [IO_WIDTH-1:0] trk_init_y = INIT_Y_RST;
    logic        [IO_WIDTH-1:0] trk_init_cov = INIT_COV_RST;
    logic        [IO_WIDTH-1:0] trk_noise = MEAS_NOISE_RST;
    longint                     trk_est [2] = '{0, 0};
    longint                     trk_prev [2] = '{0, 0};
    logic [63:0]                trk_var [2] = '{0, 0};
    logic                       trk_started = 1'b0;

    t_entry    pending [$];
    t_out_item expected_tracks [$];

    int  queued_items = 0;
    int  total_items = 0;
    int  items_in = 0;
    int  results_out = 0;
    int  cfg_writes = 0;
    int  restarts_seen = 0;
    int  error_count = 0;
    int  idle_cycles = 0;
    int  send_gap = 0;
    int  stall_left = 0;
    int  hold_left = 0;
    bit  hold_done = 1'b0;
    bit  tx_smooth = 1'b0;
    bit  rx_smooth = 1'b0;
    bit  calm = 1'b0;
    bit  in_taken = 1'b0;
    bit  cfg_taken = 1'b0;

    // floor(n * 2^FRAC / d), zero when the sum is zero
    function automatic logic [63:0] gain_frac(logic [63:0] n, logic [63:0] d);
        if (d == 0)
            return 64'd0;
        return (n << FRAC) / d;
    endfunction

    function automatic t_out_item track_step(t_in_item it);
        longint      meas [2];
        longint      pred, innov, corr, upd;
        logic [63:0] p, r, s, k, l, mag;
        t_out_item   res;
        meas[0] = $signed(it.meas_x);
        meas[1] = $signed(it.meas_y);
        if (!trk_started || it.restart) begin
            trk_est[0]  = trk_init_x;
            trk_prev[0] = trk_init_x;
            trk_est[1]  = trk_init_y;
            trk_prev[1] = trk_init_y;
            trk_var[0]  = {32'd0, trk_init_cov};
            trk_var[1]  = {32'd0, trk_init_cov};
            trk_started = 1'b1;
        end
        for (int a = 0; a < 2; a++) begin
            p     = trk_var[a];
            r     = {32'd0, trk_noise};
            s     = p + r;
            k     = gain_frac(p, s);
            l     = gain_frac(r, s);
            pred  = trk_est[a] + (meas[a] - trk_prev[a]);
            innov = meas[a] - pred;
            mag   = (innov < 0) ? 64'(-innov) : 64'(innov);
            corr  = longint'((mag * k) >> FRAC);
            if (innov < 0)
                corr = -corr;
            upd = pred + corr;
            if (upd > EST_MAX)
                upd = EST_MAX;
            else if (upd < EST_MIN)
                upd = EST_MIN;
            trk_est[a]  = upd;
            trk_var[a]  = ((p * l) >> FRAC) & 64'h0000_0000_FFFF_FFFF;
            trk_prev[a] = meas[a];
        end
        res.est_x = 32'(trk_est[0]);
        res.est_y = 32'(trk_est[1]);
        res.var_x = trk_var[0][31:0];
        res.var_y = trk_var[1][31:0];
        return res;
    endfunction

    task automatic apply_cfg(logic [CFG_IDX_W-1:0] idx, logic [IO_WIDTH-1:0] value);
        case (idx)
            REG_INIT_X:     trk_init_x = value;
            REG_INIT_Y:     trk_init_y = value;
            REG_INIT_COV:   trk_init_cov = value;
            REG_MEAS_NOISE: trk_noise = value;
            default: ;
        endcase
    endtask

    task automatic flag_error(string msg);
        if (error_count < PRINT_CAP)
            $display("tb: mismatch: %s", msg);
        error_count++;
    endtask

    task automatic check_field(string field, logic [31:0] got, logic [31:0] want);
        if (got !== want)
            flag_error($sformatf("result %0d %s got %h want %h", results_out, field, got, want));
    endtask

    task automatic queue_item(logic [31:0] x, logic [31:0] y, logic restart);
        t_entry ent;
        ent.is_cfg       = 1'b0;
        ent.index        = '0;
        ent.value        = '0;
        ent.item.meas_x  = x;
        ent.item.meas_y  = y;
        ent.item.restart = restart;
        pending = {pending, ent};
        queued_items++;
    endtask

    task automatic queue_cfg(logic [CFG_IDX_W-1:0] idx, logic [IO_WIDTH-1:0] value);
        t_entry ent;
        ent.is_cfg = 1'b1;
        ent.index  = idx;
        ent.value  = value;
        ent.item   = '0;
        pending = {pending, ent};
    endtask

    function automatic logic [31:0] pick_position();
        case ($urandom_range(0, 9))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2:       return 32'h0000_0000;
            3:       return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    // monitor: transactions on all three channels, tracker update, watchdog
    always @(posedge clk) begin : monitor_blk
        t_out_item want;
        bit        any;
        any       = 1'b0;
        in_taken  = rst_n && in_valid && !in_stall;
        cfg_taken = rst_n && cfg_valid && cfg_ready;
        if (cfg_taken) begin
            apply_cfg(cfg_index, cfg_data);
            cfg_writes++;
            any = 1'b1;
        end
        if (in_taken) begin
            expected_tracks = {expected_tracks, track_step(in_data)};
            restarts_seen += in_data.restart;
            items_in++;
            any = 1'b1;
        end
        if (rst_n && out_valid === 1'b1 && !out_stall) begin
            results_out++;
            any = 1'b1;
            if (expected_tracks.size() == 0) begin
                flag_error($sformatf("result %0d arrived with nothing expected", results_out));
            end else begin
                want = expected_tracks.pop_front();
                check_field("est_x", out_data.est_x, want.est_x);
                check_field("est_y", out_data.est_y, want.est_y);
                check_field("var_x", out_data.var_x, want.var_x);
                check_field("var_y", out_data.var_y, want.var_y);
            end
        end
        calm = items_in >= total_items - CALM_ITEMS;
        idle_cycles = any ? 0 : idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("tb: watchdog, no transaction for %0d cycles", idle_cycles);
            $display("tb: done, errors");
            $finish;
        end
    end

    // sender: items on the input channel, register writes only with nothing in flight
    always @(negedge clk) begin : drive_blk
        t_entry ent;
        logic   nxt_in_valid, nxt_cfg_valid;
        nxt_in_valid  = in_valid & ~in_taken;
        nxt_cfg_valid = cfg_valid & ~cfg_taken;
        if (in_valid && in_taken) begin
            if ($urandom_range(0, 49) == 0)
                tx_smooth = !tx_smooth;
            if (!calm && !tx_smooth && hold_left == 0 && $urandom_range(0, 2) == 0)
                send_gap = $urandom_range(1, 13);
        end
        if (rst_n && !nxt_in_valid && !nxt_cfg_valid) begin
            if (send_gap > 0) begin
                send_gap--;
            end else if (pending.size() > 0) begin
                if (!pending[0].is_cfg) begin
                    ent = pending.pop_front();
                    nxt_in_valid = 1'b1;
                    in_data <= ent.item;
                end else if (expected_tracks.size() == 0) begin
                    ent = pending.pop_front();
                    nxt_cfg_valid = 1'b1;
                    cfg_index <= ent.index;
                    cfg_data  <= ent.value;
                end
            end
        end
        in_valid  <= nxt_in_valid;
        cfg_valid <= nxt_cfg_valid;
    end

    // receiver: random stall bursts plus one long hold-off while items keep coming
    always @(negedge clk) begin : stall_blk
        int   left;
        logic nxt;
        left = hold_left;
        if (!hold_done && items_in >= HOLD_AT && in_valid) begin
            left = HOLD_LEN;
            hold_done = 1'b1;
        end
        if ($urandom_range(0, 149) == 0)
            rx_smooth = !rx_smooth;
        if (left > 0) begin
            left--;
            nxt = 1'b1;
        end else if (calm || rx_smooth) begin
            stall_left = 0;
            nxt = 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            nxt = 1'b1;
        end else if ($urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(0, 12);
            nxt = 1'b1;
        end else begin
            nxt = 1'b0;
        end
        hold_left <= left;
        out_stall <= nxt;
    end

    initial begin : main_blk
        int span;
        // reset settings, restart on the very first item, extreme positions
        queue_item(32'h0004_0000, 32'h0000_0000, 1'b1);
        queue_item(32'h7FFF_FFFF, 32'h8000_0000, 1'b0);
        queue_item(32'h8000_0000, 32'h7FFF_FFFF, 1'b0);
        queue_item(32'h0000_0000, 32'hFFFF_FFFF, 1'b0);
        queue_item(32'hFFFF_FFFF, 32'h0000_0000, 1'b0);
        queue_item(32'h0012_3456, 32'hFFED_CBA9, 1'b1);
        // full-scale settings, writes past the map are dropped
        queue_cfg(REG_INIT_X, 32'h7FFF_FFFF);
        queue_cfg(REG_INIT_Y, 32'h8000_0000);
        queue_cfg(REG_INIT_COV, 32'hFFFF_FFFF);
        queue_cfg(REG_MEAS_NOISE, 32'hFFFF_FFFF);
        queue_cfg(REG_UNUSED_LO, 32'h0000_0000);
        queue_cfg(REG_UNUSED_HI, 32'hFFFF_FFFF);
        queue_item(32'h8000_0000, 32'h7FFF_FFFF, 1'b1);
        queue_item(32'h7FFF_FFFF, 32'h8000_0000, 1'b0);
        queue_item(32'h5555_5555, 32'hAAAA_AAAA, 1'b0);
        // no noise and no variance: gain sum is zero
        queue_cfg(REG_INIT_COV, 32'h0000_0000);
        queue_cfg(REG_MEAS_NOISE, 32'h0000_0000);
        queue_item(32'hAAAA_AAAA, 32'h5555_5555, 1'b1);
        queue_item(32'h0001_0000, 32'hFFFF_0000, 1'b0);
        // no noise with variance: gain of exactly one
        queue_cfg(REG_INIT_COV, 32'h0001_0000);
        queue_item(32'h0100_0000, 32'hFF00_0000, 1'b1);
        queue_item(32'h0000_0001, 32'hFFFF_FFFE, 1'b0);
        // tiny noise against huge variance
        queue_cfg(REG_MEAS_NOISE, 32'h0000_0001);
        queue_cfg(REG_INIT_COV, 32'hFFFF_FFFF);
        queue_item(32'h1234_5678, 32'h8765_4321, 1'b1);
        queue_item(32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0);
        queue_item(32'h8000_0000, 32'h8000_0000, 1'b0);
        // huge noise against tiny variance
        queue_cfg(REG_INIT_X, 32'h8000_0000);
        queue_cfg(REG_INIT_Y, 32'h7FFF_FFFF);
        queue_cfg(REG_INIT_COV, 32'h0000_0001);
        queue_cfg(REG_MEAS_NOISE, 32'hFFFF_FFFF);
        queue_item(32'h0000_0000, 32'h0000_0000, 1'b1);
        queue_item(32'hFFFF_FFFF, 32'h0000_0001, 1'b0);

        // random phases, each with fresh settings between them
        span = queued_items + RANDOM_ITEMS;
        while (queued_items < span) begin
            queue_cfg(REG_INIT_X, pick_position());
            queue_cfg(REG_INIT_Y, pick_position());
            case ($urandom_range(0, 5))
                0:       queue_cfg(REG_INIT_COV, 32'h0000_0000);
                1:       queue_cfg(REG_INIT_COV, 32'hFFFF_FFFF);
                2:       queue_cfg(REG_INIT_COV, $urandom_range(0, 32'h0004_0000));
                default: queue_cfg(REG_INIT_COV, $urandom);
            endcase
            case ($urandom_range(0, 6))
                0:       queue_cfg(REG_MEAS_NOISE, 32'h0000_0000);
                1:       queue_cfg(REG_MEAS_NOISE, 32'h0000_0001);
                2:       queue_cfg(REG_MEAS_NOISE, 32'hFFFF_FFFF);
                3:       queue_cfg(REG_MEAS_NOISE, $urandom_range(1, 32'h0001_0000));
                default: queue_cfg(REG_MEAS_NOISE, $urandom);
            endcase
            if ($urandom_range(0, 3) == 0)
                queue_cfg(CFG_IDX_W'($urandom_range(REG_UNUSED_LO, REG_UNUSED_HI)), $urandom);
            // half the phases carry the running filter across the new settings
            queue_item(pick_position(), pick_position(), 1'($urandom_range(0, 1)));
            repeat ($urandom_range(30, 150))
                queue_item(pick_position(), pick_position(), $urandom_range(0, 11) == 0);
        end
        total_items = queued_items;

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (pending.size() != 0 || in_valid || cfg_valid || expected_tracks.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("tb: %0d measurements tracked, %0d with restart, %0d results checked",
                 items_in, restarts_seen, results_out);
        $display("tb: %0d register writes incl. zero noise, full-scale and unmapped indexes",
                 cfg_writes);
        if (error_count == 0) begin
            $display("tb: done, clean");
        end else begin
            $display("tb: done, errors");
        end
        $finish;
    end

endmodule
